>>> rtl/gbs_pkg.sv
package gbs_pkg;

   localparam int MaxBoxes  = 64;
   localparam int IdxBits   = 6;
   localparam int CntBits   = 7;
   localparam int CoordBits = 16;
   localparam int PixelOne  = 16;
   localparam logic [15:0] ThresholdReset = 16'd45875;

   typedef struct packed {
      logic [15:0] left_edge;
      logic [15:0] top_edge;
      logic [15:0] right_edge;
      logic [15:0] bottom_edge;
      logic [15:0] confidence;
      logic        final_box;
   } req_type;

   typedef struct packed {
      logic [5:0] kept_index;
      logic       final_kept;
   } rsp_type;

   // One stored entry: corners, score and arrival index.
   typedef struct packed {
      logic [15:0] x0;
      logic [15:0] y0;
      logic [15:0] x1;
      logic [15:0] y1;
      logic [15:0] score;
      logic [5:0]  origin;
   } entry_type;

   typedef enum logic [3:0] {
      ST_LOAD,
      ST_SORT_RD,
      ST_SORT_CMP,
      ST_SORT_WR,
      ST_PICK_RD,
      ST_PICK_CHK,
      ST_EMIT,
      ST_SUP_RD,
      ST_SUP_CHK,
      ST_IOU
   } state_type;

   // Read/write request to the entry memory.
   typedef struct packed {
      logic            wr_en;
      logic [5:0]      wr_addr;
      entry_type       wr_data;
      logic [5:0]      rd_addr_a;
      logic [5:0]      rd_addr_b;
   } mem_req_type;

endpackage

>>> rtl/gbs_entry_ram.sv
module gbs_entry_ram (
   input  logic                  clock,
   input  gbs_pkg::mem_req_type  mem_req,
   output gbs_pkg::entry_type    rd_data_a,
   output gbs_pkg::entry_type    rd_data_b
);

   gbs_pkg::entry_type mem [gbs_pkg::MaxBoxes];

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         mem[mem_req.wr_addr] <= mem_req.wr_data;
      end
      rd_data_a <= mem[mem_req.rd_addr_a];
      rd_data_b <= mem[mem_req.rd_addr_b];
   end

endmodule

>>> rtl/gbs_iou_unit.sv
module gbs_iou_unit (
   input  logic               clock,
   input  logic               start,
   input  gbs_pkg::entry_type box_a,
   input  gbs_pkg::entry_type box_b,
   input  logic [15:0]        threshold,
   output logic               done,
   output logic               suppress
);

   // Stage 1: intersection extents and box extents.
   logic signed [17:0] iw_in, ih_in, aw_in, ah_in, bw_in, bh_in;
   logic               pos_in;
   logic [15:0]        ix0, iy0, ix1, iy1;

   always_comb begin
      ix0 = (box_a.x0 > box_b.x0) ? box_a.x0 : box_b.x0;
      iy0 = (box_a.y0 > box_b.y0) ? box_a.y0 : box_b.y0;
      ix1 = (box_a.x1 < box_b.x1) ? box_a.x1 : box_b.x1;
      iy1 = (box_a.y1 < box_b.y1) ? box_a.y1 : box_b.y1;
      iw_in = $signed({2'b0, ix1}) - $signed({2'b0, ix0});
      ih_in = $signed({2'b0, iy1}) - $signed({2'b0, iy0});
      aw_in = $signed({2'b0, box_a.x1}) - $signed({2'b0, box_a.x0})
              + 18'sd16;
      ah_in = $signed({2'b0, box_a.y1}) - $signed({2'b0, box_a.y0})
              + 18'sd16;
      bw_in = $signed({2'b0, box_b.x1}) - $signed({2'b0, box_b.x0})
              + 18'sd16;
      bh_in = $signed({2'b0, box_b.y1}) - $signed({2'b0, box_b.y0})
              + 18'sd16;
      pos_in = (iw_in > 18'sd0) && (ih_in > 18'sd0);
   end

   logic signed [17:0] iw_ff, ih_ff, aw_ff, ah_ff, bw_ff, bh_ff;
   logic               pos_ff, v1_ff, v2_ff, v3_ff, v4_ff;

   // Stage 2: three areas.
   logic signed [35:0] inter_ff, area_a_ff, area_b_ff;
   // Stage 3: union, then the products in stage 4.
   logic signed [37:0] uni_ff;
   logic [35:0]        inter2_ff;
   logic               pos2_ff, pos3_ff;
   logic [53:0]        lhs_ff;
   logic [55:0]        rhs_ff;

   always_ff @(posedge clock) begin
      iw_ff <= iw_in + 18'sd16;
      ih_ff <= ih_in + 18'sd16;
      aw_ff <= aw_in;  ah_ff <= ah_in;
      bw_ff <= bw_in;  bh_ff <= bh_in;
      pos_ff <= pos_in;
      inter_ff  <= iw_ff * ih_ff;
      area_a_ff <= aw_ff * ah_ff;
      area_b_ff <= bw_ff * bh_ff;
      pos2_ff   <= pos_ff;
      uni_ff    <= 38'(area_a_ff) + 38'(area_b_ff) - 38'(inter_ff);
      inter2_ff <= inter_ff;
      pos3_ff   <= pos2_ff;
      lhs_ff    <= {2'b0, inter2_ff, 16'd0};
      rhs_ff    <= 56'($signed({1'b0, threshold})) * 56'(uni_ff);
      suppress  <= pos3_ff && ($signed({2'b0, lhs_ff}) > $signed(rhs_ff));
   end

   always_ff @(posedge clock) begin
      v1_ff <= start;
      v2_ff <= v1_ff;
      v3_ff <= v2_ff;
      v4_ff <= v3_ff;
      done  <= v4_ff;
   end

endmodule

>>> rtl/greedy_box_suppression_unit.sv
// Greedy non-maximum suppression. Boxes are taken one per cycle into an
// entry memory while no result waits in the output register. When a box
// carries final_box, or when 64 boxes are loaded, the set is sorted by
// score (stable bubble sort, highest first; a compare reads the pair and
// then compares it, and a swap writes the two entries one after the other).
// Then the best live box is chosen, every later live box is tested against
// it by an overlap unit, and only then is the chosen box emitted as one
// item, so that its last-item flag already reflects the suppression it
// caused. No box is accepted until the last item of the set has been
// taken. Live marks sit in flip-flops and are cleared when the set ends.
// The threshold register may be written while idle.
module greedy_box_suppression_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  gbs_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output gbs_pkg::rsp_type  rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [15:0]       csr_data
);

   gbs_pkg::state_type state_ff, state_in;
   logic [15:0] thr_ff;
   logic [6:0]  cnt_ff, cnt_in;
   logic [5:0]  i_ff, i_in, j_ff, j_in;
   logic [5:0]  pass_ff, pass_in;
   logic [63:0] alive_ff, alive_in;
   gbs_pkg::entry_type a_ff, a_in, b_ff, b_in;
   logic        rsp_valid_ff, rsp_valid_in;
   gbs_pkg::rsp_type rsp_ff, rsp_in;
   gbs_pkg::mem_req_type mreq;
   gbs_pkg::entry_type   rd_a, rd_b;
   logic iou_start, iou_done, iou_sup;

   gbs_entry_ram u_ram (
      .clock(clock), .mem_req(mreq), .rd_data_a(rd_a), .rd_data_b(rd_b)
   );

   // The candidate box comes straight from the read port in the cycle
   // that starts the overlap test.
   gbs_iou_unit u_iou (
      .clock(clock), .start(iou_start), .box_a(a_ff), .box_b(rd_a),
      .threshold(thr_ff), .done(iou_done), .suppress(iou_sup)
   );

   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= gbs_pkg::ST_LOAD;
         thr_ff       <= gbs_pkg::ThresholdReset;
         cnt_ff       <= '0;
         alive_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         alive_ff     <= alive_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid) begin
            thr_ff <= csr_data;
         end
      end
      i_ff    <= i_in;
      j_ff    <= j_in;
      pass_ff <= pass_in;
      a_ff    <= a_in;
      b_ff    <= b_in;
      rsp_ff  <= rsp_in;
   end

   // Does any live box remain after index k?
   function automatic logic any_after(input logic [63:0] m, input logic [5:0] k,
                                      input logic [6:0] n);
      logic r;
      r = 1'b0;
      for (int q = 0; q < 64; q++) begin
         if (q > int'(k) && q < int'(n) && m[q]) r = 1'b1;
      end
      return r;
   endfunction

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      pass_in      = pass_ff;
      alive_in     = alive_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      req_ready    = 1'b0;
      iou_start    = 1'b0;
      mreq         = '0;
      mreq.rd_addr_a = j_ff;
      mreq.rd_addr_b = 6'(j_ff + 6'd1);
      case (state_ff)
         gbs_pkg::ST_LOAD: begin
            req_ready = !rsp_valid_ff;
            mreq.wr_addr = cnt_ff[5:0];
            mreq.wr_data = '{x0: req_data.left_edge, y0: req_data.top_edge,
                             x1: req_data.right_edge, y1: req_data.bottom_edge,
                             score: req_data.confidence, origin: cnt_ff[5:0]};
            if (req_valid && req_ready) begin
               mreq.wr_en = 1'b1;
               cnt_in = 7'(cnt_ff + 7'd1);
               if (req_data.final_box || cnt_ff == 7'd63) begin
                  pass_in  = '0;
                  j_in     = '0;
                  state_in = gbs_pkg::ST_SORT_RD;
               end
            end
         end
         gbs_pkg::ST_SORT_RD: begin
            // Pass p compares j,j+1 for j+1 < n-p.
            if (7'(j_ff) + 7'd1 >= cnt_ff - 7'(pass_ff)) begin
               if (7'(pass_ff) + 7'd2 >= cnt_ff) begin
                  alive_in = '0;
                  for (int q = 0; q < 64; q++) alive_in[q] = (q < int'(cnt_ff));
                  i_in     = '0;
                  state_in = gbs_pkg::ST_PICK_CHK;
               end else begin
                  pass_in = 6'(pass_ff + 6'd1);
                  j_in    = '0;
               end
            end else begin
               state_in = gbs_pkg::ST_SORT_CMP;
            end
         end
         gbs_pkg::ST_SORT_CMP: begin
            a_in = rd_a;
            b_in = rd_b;
            if (rd_a.score < rd_b.score) begin
               state_in = gbs_pkg::ST_SORT_WR;
            end else begin
               j_in     = 6'(j_ff + 6'd1);
               state_in = gbs_pkg::ST_SORT_RD;
            end
         end
         gbs_pkg::ST_SORT_WR: begin
            // First half of the swap writes b at j; the next state puts a
            // at j+1.
            mreq.wr_en   = 1'b1;
            mreq.wr_addr = j_ff;
            mreq.wr_data = b_ff;
            a_in = a_ff;
            state_in = gbs_pkg::ST_PICK_RD;
         end
         gbs_pkg::ST_PICK_RD: begin
            // Second half of the swap.
            mreq.wr_en   = 1'b1;
            mreq.wr_addr = 6'(j_ff + 6'd1);
            mreq.wr_data = a_ff;
            j_in     = 6'(j_ff + 6'd1);
            state_in = gbs_pkg::ST_SORT_RD;
         end
         gbs_pkg::ST_PICK_CHK: begin
            mreq.rd_addr_a = i_ff;
            if (!alive_ff[i_ff]) begin
               if (7'(i_ff) + 7'd1 >= cnt_ff) begin
                  cnt_in   = '0;
                  state_in = gbs_pkg::ST_LOAD;
               end else begin
                  i_in = 6'(i_ff + 6'd1);
               end
            end else begin
               state_in = gbs_pkg::ST_EMIT;
            end
         end
         gbs_pkg::ST_EMIT: begin
            // The chosen box is held and always leaves the live set.
            a_in = rd_a;
            alive_in[i_ff] = 1'b0;
            j_in     = 6'(i_ff + 6'd1);
            state_in = gbs_pkg::ST_SUP_RD;
         end
         gbs_pkg::ST_SUP_RD: begin
            mreq.rd_addr_a = j_ff;
            if (7'(j_ff) >= cnt_ff || j_ff == 6'd0) begin
               // Suppression by the chosen box is finished, so the live
               // marks now tell whether it is the last kept box. It is
               // emitted once the output register is free.
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_in = 1'b1;
                  rsp_in.kept_index = a_ff.origin;
                  rsp_in.final_kept = !any_after(alive_ff, i_ff, cnt_ff);
                  if (7'(i_ff) + 7'd1 >= cnt_ff) begin
                     cnt_in   = '0;
                     alive_in = '0;
                     state_in = gbs_pkg::ST_LOAD;
                  end else begin
                     i_in     = 6'(i_ff + 6'd1);
                     state_in = gbs_pkg::ST_PICK_CHK;
                  end
               end
            end else if (!alive_ff[j_ff]) begin
               j_in = 6'(j_ff + 6'd1);
            end else begin
               state_in = gbs_pkg::ST_SUP_CHK;
            end
         end
         gbs_pkg::ST_SUP_CHK: begin
            // The candidate is on the read port now; start the test.
            iou_start = 1'b1;
            state_in  = gbs_pkg::ST_IOU;
         end
         gbs_pkg::ST_IOU: begin
            if (iou_done) begin
               if (iou_sup) alive_in[j_ff] = 1'b0;
               j_in     = 6'(j_ff + 6'd1);
               state_in = gbs_pkg::ST_SUP_RD;
            end
         end
         default: state_in = gbs_pkg::ST_LOAD;
      endcase
   end

`ifndef SYNTHESIS
   assert property (@(posedge clock) disable iff (reset)
      req_ready |-> state_ff == gbs_pkg::ST_LOAD)
      else $error("box taken outside loading");
   assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= 7'd64)
      else $error("load count overflow");
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> $stable(rsp_data))
      else $error("result changed while stalled");
`endif

endmodule

>>> tb/testbench.sv
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   // Keeps the expected kept boxes and mirrors the suppression algorithm.
   class kept_box_board;
      logic [63:0] corners [$];
      logic [15:0] scores [$];
      logic [15:0] threshold;
      gbs_pkg::rsp_type pending [$];
      int          errors;

      function new();
         threshold = gbs_pkg::ThresholdReset;
         errors = 0;
      endfunction

      // Returns 1 when box b overlaps box a by more than the threshold.
      function bit too_close(logic [63:0] a, logic [63:0] b);
         longint ax0, ay0, ax1, ay1, bx0, by0, bx1, by1, ix0, iy0, ix1, iy1;
         longint inter, uni;
         ax0 = a[63:48]; ay0 = a[47:32]; ax1 = a[31:16]; ay1 = a[15:0];
         bx0 = b[63:48]; by0 = b[47:32]; bx1 = b[31:16]; by1 = b[15:0];
         ix0 = ax0 > bx0 ? ax0 : bx0;
         iy0 = ay0 > by0 ? ay0 : by0;
         ix1 = ax1 < bx1 ? ax1 : bx1;
         iy1 = ay1 < by1 ? ay1 : by1;
         if (!(ix1 - ix0 > 0 && iy1 - iy0 > 0)) return 0;
         inter = (ix1 - ix0 + gbs_pkg::PixelOne) * (iy1 - iy0 + gbs_pkg::PixelOne);
         uni = (ax1 - ax0 + gbs_pkg::PixelOne) * (ay1 - ay0 + gbs_pkg::PixelOne)
             + (bx1 - bx0 + gbs_pkg::PixelOne) * (by1 - by0 + gbs_pkg::PixelOne)
             - inter;
         return inter * 65536 > longint'(threshold) * uni;
      endfunction

      // Notes one accepted box; a closed set produces its kept indexes.
      function void note_box(gbs_pkg::req_type r);
         int order [$];
         bit alive [$];
         int n, t;
         gbs_pkg::rsp_type e;
         corners.push_back({r.left_edge, r.top_edge, r.right_edge, r.bottom_edge});
         scores.push_back(r.confidence);
         if (!r.final_box && corners.size() < gbs_pkg::MaxBoxes) return;
         n = corners.size();
         for (int i = 0; i < n; i++) order.push_back(i);
         // Stable ordering: an entry passes another only with a higher score.
         for (int i = 0; i + 1 < n; i++)
            for (int j = 0; j + 1 < n - i; j++)
               if (scores[order[j]] < scores[order[j+1]]) begin
                  t = order[j]; order[j] = order[j+1]; order[j+1] = t;
               end
         for (int i = 0; i < n; i++) alive.push_back(1);
         for (int i = 0; i < n; i++) begin
            if (alive[i]) begin
               alive[i] = 0;
               e.kept_index = 6'(order[i]);
               e.final_kept = 0;
               pending.push_back(e);
               for (int j = i + 1; j < n; j++)
                  if (alive[j] && too_close(corners[order[i]], corners[order[j]]))
                     alive[j] = 0;
            end
         end
         pending[pending.size()-1].final_kept = 1;
         corners.delete();
         scores.delete();
      endfunction

      function void check_kept(gbs_pkg::rsp_type got);
         gbs_pkg::rsp_type e;
         if (pending.size() == 0) begin
            $error("unexpected kept box index %0d", got.kept_index);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (got.kept_index !== e.kept_index) begin
            $error("kept_index expected %0d actual %0d", e.kept_index, got.kept_index);
            errors++;
         end
         if (got.final_kept !== e.final_kept) begin
            $error("final_kept expected %0d actual %0d", e.final_kept, got.final_kept);
            errors++;
         end
      endfunction
   endclass

   logic    clock = 0;
   logic    reset = 1;
   logic    req_valid = 0;
   logic    req_ready;
   gbs_pkg::req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 0;
   gbs_pkg::rsp_type rsp_data;
   logic    csr_valid = 0;
   logic    csr_ready;
   logic [15:0] csr_data = '0;

   kept_box_board board = new();
   bit quiet_phase = 0;   // no idling on either side near the end
   bit hold_rsp = 0;      // long receiver stall for the pressure test
   int box_count = 0;

   greedy_box_suppression_unit uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   always #5 clock = ~clock;

   // Every accepted item is passed to the scoreboard at the edge it moves.
   always @(posedge clock) begin
      if (!reset && req_valid && req_ready) board.note_box(req_data);
      if (!reset && rsp_valid && rsp_ready) board.check_kept(rsp_data);
   end

   // Receiver: ready goes low in random bursts unless the run is in its
   // quiet phase; the hold flag keeps it low for a long stretch.
   initial begin
      int gap;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (hold_rsp) begin
            rsp_ready <= 0;
         end else if (!quiet_phase && $urandom_range(0, 9) == 0) begin
            gap = $urandom_range(1, 13);
            rsp_ready <= 0;
            repeat (gap) @(posedge clock);
            rsp_ready <= 1;
         end else begin
            rsp_ready <= 1;
         end
      end
   end

   // Offers one box and waits until it is accepted, with an optional gap
   // before. Valid stays high between boxes sent back to back.
   task automatic send_box(input gbs_pkg::req_type r);
      if (!quiet_phase && $urandom_range(0, 7) == 0) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
      req_valid <= 1;
      req_data <= r;
      do @(posedge clock); while (!req_ready);
      box_count++;
   endtask

   function automatic gbs_pkg::req_type box_of(int x0, int y0, int x1, int y1,
                                               int s, bit last);
      gbs_pkg::req_type r;
      r.left_edge = 16'(x0); r.top_edge = 16'(y0);
      r.right_edge = 16'(x1); r.bottom_edge = 16'(y1);
      r.confidence = 16'(s); r.final_box = last;
      return r;
   endfunction

   // A random box; mostly well-formed and clustered so overlaps are common.
   function automatic gbs_pkg::req_type random_box(bit last);
      gbs_pkg::req_type r;
      int cx, cy, w, h;
      if ($urandom_range(0, 9) == 0) begin
         r.left_edge   = 16'($urandom);
         r.top_edge    = 16'($urandom);
         r.right_edge  = 16'($urandom);
         r.bottom_edge = 16'($urandom);
         r.confidence  = 16'($urandom);
      end else begin
         cx = $urandom_range(0, 1200);
         cy = $urandom_range(0, 1200);
         w = $urandom_range(0, 600);
         h = $urandom_range(0, 600);
         r.left_edge = 16'(cx); r.top_edge = 16'(cy);
         r.right_edge = 16'(cx + w); r.bottom_edge = 16'(cy + h);
         r.confidence = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 3) * 16384)
                                                    : 16'($urandom);
      end
      r.final_box = last;
      return r;
   endfunction

   // Waits until the last set has drained, plus the unit's own tail.
   task automatic drain();
      req_valid <= 0;
      @(posedge clock);
      while (board.pending.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   task automatic write_threshold(input logic [15:0] value);
      csr_valid <= 1;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 0;
      board.threshold = value;
   endtask

   task automatic random_set(input int n);
      for (int i = 0; i < n; i++) send_box(random_box(i == n - 1));
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed part at the reset threshold: extremes, ties, degenerate
      // boxes, an identical pair and a lone box.
      send_box(box_of(0, 0, 0, 0, 0, 1));
      send_box(box_of(16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 1));
      send_box(box_of(0, 0, 160, 160, 100, 0));
      send_box(box_of(0, 0, 160, 160, 100, 0));
      send_box(box_of(8, 8, 168, 168, 200, 0));
      send_box(box_of(500, 500, 100, 100, 300, 0));
      send_box(box_of(100, 100, 50, 50, 300, 0));
      send_box(box_of(0, 0, 16'hffff, 16'hffff, 16'hffff, 1));
      send_box(box_of(16'haaaa, 16'h5555, 16'haaaa, 16'h5555, 16'h5555, 0));
      send_box(box_of(16'h5555, 16'haaaa, 16'hffff, 16'hffff, 16'haaaa, 1));
      drain();

      // Threshold zero: any positive overlap suppresses.
      write_threshold(16'h0000);
      send_box(box_of(0, 0, 320, 320, 10, 0));
      send_box(box_of(300, 300, 600, 600, 20, 0));
      send_box(box_of(700, 700, 710, 710, 20, 1));
      random_set(6);
      drain();

      // A final mark on the 63rd box, then one unmarked box that opens the next set.
      write_threshold(16'hffff);
      random_set(64 - 1);
      send_box(random_box(0));
      drain();

      // Pressure: the receiver stalls while sets keep arriving.
      write_threshold(16'h8000);
      fork
         begin
            hold_rsp = 1;
            repeat (3000) @(posedge clock);
            hold_rsp = 0;
         end
         begin
            random_set(4);
            random_set(5);
         end
      join
      drain();

      // Random sets over several thresholds; the last few without idling.
      while (box_count < 370) begin
         if ($urandom_range(0, 3) == 0) begin
            drain();
            write_threshold($urandom_range(0, 3) == 0 ? 16'h0000 : 16'($urandom));
         end
         if (box_count > 330) quiet_phase = 1;
         random_set($urandom_range(0, 15) == 0 ? $urandom_range(30, 64)
                                               : $urandom_range(1, 10));
      end
      drain();

      if (board.errors == 0 && board.pending.size() == 0)
         $display("greedy_box_suppression_unit test passed");
      else
         $display("greedy_box_suppression_unit test failed");
      $finish;
   end

   initial begin
      #20ms;
      $display("greedy_box_suppression_unit test failed");
      $finish;
   end
endmodule

>>> filelist.f
rtl/gbs_pkg.sv
rtl/gbs_entry_ram.sv
rtl/gbs_iou_unit.sv
rtl/greedy_box_suppression_unit.sv
tb/testbench.sv
